// ===== hdl/hrs_pkg.sv =====
// Package with item types, codes and controller interface types for the hash ring table.
package hrs_pkg;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int OWNER_W = 8;
  localparam int STS_W   = 2;
  localparam int CNT_W   = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key_hash;
    logic [OWNER_W-1:0] owner_in;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [OWNER_W-1:0] owner_out;
    logic [CNT_W-1:0]   entry_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic rd_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== hdl/hrs_ctrl.sv =====
// Sequencer for the hash ring table: accept, scan, drain and commit steps.
module hrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrs_pkg::ctl_sts_t sts,
  output hrs_pkg::ctl_cmd_t cmd
);
  import hrs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.cnt_zero ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read data lands in the accumulators this cycle
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/hrs_datapath.sv =====
// Datapath for the hash ring table: entry memory, scan accumulators and result register.
module hrs_datapath #(
  parameter int CAPACITY  = 64,
  parameter int HASH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hrs_pkg::in_item_t  in_data,
  input  hrs_pkg::ctl_cmd_t  cmd,
  output hrs_pkg::ctl_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output hrs_pkg::out_item_t out_data
);
  import hrs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [HASH_BITS-1:0] pos_mem [CAPACITY];
  logic [OWNER_W-1:0]   own_mem [CAPACITY];

  logic [OP_W-1:0]      op_r;
  logic [HASH_BITS-1:0] key_r;
  logic [OWNER_W-1:0]   owner_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;

  logic [AW-1:0]        addr_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        rd_idx_r;
  logic [HASH_BITS-1:0] rd_pos_r;
  logic [OWNER_W-1:0]   rd_own_r;
  logic [AW-1:0]        last_idx;

  logic                 found_r;
  logic [AW-1:0]        found_idx_r;
  logic [HASH_BITS-1:0] min_pos_r;
  logic [OWNER_W-1:0]   min_own_r;
  logic                 have_succ_r;
  logic [HASH_BITS-1:0] succ_pos_r;
  logic [OWNER_W-1:0]   succ_own_r;
  logic [HASH_BITS-1:0] last_pos_r;
  logic [OWNER_W-1:0]   last_own_r;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [HASH_BITS-1:0] wr_pos;
  logic [OWNER_W-1:0]   wr_own;
  logic                 full;

  out_item_t            res;
  out_item_t            out_r;
  logic                 out_valid_r;

  assign last_idx     = AW'(count_r - CW'(1));
  assign full         = (count_r == CW'(CAPACITY));
  assign sts.cnt_zero = (count_r == '0);
  assign sts.rd_last  = (addr_r == last_idx);
  assign sts.out_free = !out_valid_r || out_ready;

  // Item capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      key_r   <= HASH_BITS'(in_data.key_hash);
      owner_r <= in_data.owner_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.rd) begin
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_idx_r <= addr_r;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      own_mem[wr_addr] <= wr_own;
    end
    if (cmd.rd) begin
      rd_pos_r <= pos_mem[addr_r];
      rd_own_r <= own_mem[addr_r];
    end
  end

  // Scan accumulators: match, ring minimum, successor, last slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      have_succ_r <= 1'b0;
    end else if (cmd.load) begin
      found_r     <= 1'b0;
      have_succ_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_pos_r == key_r) begin
        found_r <= 1'b1;
      end
      if (rd_pos_r >= key_r && (!have_succ_r || rd_pos_r < succ_pos_r)) begin
        have_succ_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (rd_pos_r == key_r) begin
        found_idx_r <= rd_idx_r;
      end
      if (rd_idx_r == '0 || rd_pos_r < min_pos_r) begin
        min_pos_r <= rd_pos_r;
        min_own_r <= rd_own_r;
      end
      if (rd_pos_r >= key_r && (!have_succ_r || rd_pos_r < succ_pos_r)) begin
        succ_pos_r <= rd_pos_r;
        succ_own_r <= rd_own_r;
      end
      if (rd_idx_r == last_idx) begin
        last_pos_r <= rd_pos_r;
        last_own_r <= rd_own_r;
      end
    end
  end

  // Result and table update at commit
  always_comb begin
    res.status    = ST_NOT_FOUND;
    res.owner_out = '0;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_pos        = key_r;
    wr_own        = owner_r;
    case (op_r)
      OP_INSERT: begin
        if (found_r) begin
          res.status = ST_DUPLICATE;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_OK;
          wr_en      = cmd.commit;
          count_nxt  = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (found_r) begin
          // move the last slot into the hole
          res.status = ST_OK;
          wr_en      = cmd.commit;
          wr_addr    = found_idx_r;
          wr_pos     = last_pos_r;
          wr_own     = last_own_r;
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_LOOKUP: begin
        if (count_r != '0) begin
          res.status    = ST_OK;
          res.owner_out = have_succ_r ? succ_own_r : min_own_r;
        end
      end
      default: begin
        res.status = ST_NOT_FOUND;
      end
    endcase
    res.entry_count = CNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/hash_ring_successor_table_unit.sv =====
// Top level of the consistent-hash ring successor table.
// Holds up to CAPACITY (ring position, owner) entries packed in an on-chip memory and serves
// insert, remove and lookup items one at a time. Every item scans the occupied slots through
// the memory's single read port, one slot per cycle, then passes a drain step before its result
// is committed; an empty table skips both the scan and the drain. The result sits in an output
// register, so the next item is accepted while it waits to be taken; a finished item holds
// until the previous result is taken. Ring positions are the low HASH_BITS bits of key_hash.
// No clearing pass is needed after reset: only slots below the entry count are ever read.
module hash_ring_successor_table_unit #(
  parameter int CAPACITY  = 64,
  parameter int HASH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hrs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hrs_pkg::out_item_t out_data
);
  import hrs_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  hrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hrs_datapath #(
    .CAPACITY  (CAPACITY),
    .HASH_BITS (HASH_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the hash ring successor table: directed cases and random traffic.
`timescale 1ns / 100ps

module testbench;
  import hrs_pkg::*;

  localparam int RING_CAP = 64;
  localparam int SETTLE_CYCLES = RING_CAP + 8;
  localparam int FILL_SPAN = 150;
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Predictor state: entries packed in slots below ring_used
  logic [KEY_W-1:0]   ring_pos [RING_CAP];
  logic [OWNER_W-1:0] ring_own [RING_CAP];
  int                 ring_used;

  out_item_t ring_expect_q[$];
  out_item_t want_res;
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        rand_sent;

  hash_ring_successor_table_unit #(
    .CAPACITY (RING_CAP),
    .HASH_BITS(KEY_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one item to the predictor table and return the result it should produce
  function automatic out_item_t ring_apply(input in_item_t it);
    out_item_t res;
    int hit;
    int succ;
    int low;
    hit = -1;
    res.status = ST_NOT_FOUND;
    res.owner_out = '0;
    for (int i = 0; i < ring_used; i++) begin
      if (ring_pos[i] == it.key_hash) hit = i;
    end
    case (it.op)
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = ST_DUPLICATE;
        end else if (ring_used >= RING_CAP) begin
          res.status = ST_FULL;
        end else begin
          ring_pos[ring_used] = it.key_hash;
          ring_own[ring_used] = it.owner_in;
          ring_used++;
          res.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // last slot fills the hole
          ring_pos[hit] = ring_pos[ring_used - 1];
          ring_own[hit] = ring_own[ring_used - 1];
          ring_used--;
          res.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (ring_used > 0) begin
          succ = -1;
          low = 0;
          for (int i = 0; i < ring_used; i++) begin
            if (ring_pos[i] < ring_pos[low]) low = i;
            if (ring_pos[i] >= it.key_hash && (succ < 0 || ring_pos[i] < ring_pos[succ]))
              succ = i;
          end
          // wrap to the lowest position when nothing sits at or above the key
          res.owner_out = (succ < 0) ? ring_own[low] : ring_own[succ];
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    res.entry_count = ring_used[CNT_W-1:0];
    return res;
  endfunction

  // Key that hits a stored entry with the given odds, else a neighbor, an extreme or noise
  function automatic logic [KEY_W-1:0] pick_ring_key(input int hit_pct);
    logic [KEY_W-1:0] k;
    int r;
    k = $urandom;
    r = $urandom_range(9);
    if (ring_used > 0 && $urandom_range(99) < hit_pct) begin
      k = ring_pos[$urandom_range(ring_used - 1)];
    end else if (ring_used > 0 && r < 2) begin
      k = ring_pos[$urandom_range(ring_used - 1)];
      k = (r == 0) ? k + 32'd1 : k - 32'd1;
    end else if (r == 2) begin
      k = '0;
    end else if (r == 3) begin
      k = '1;
    end
    return k;
  endfunction

  function automatic in_item_t random_ring_item(input bit fill_phase);
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it.owner_in = OWNER_W'($urandom);
    if (r < 3) begin
      it.op = OP_UNDEF;
      it.key_hash = $urandom;
    end else if (r < (fill_phase ? 73 : 13)) begin
      it.op = OP_INSERT;
      it.key_hash = pick_ring_key(15);
    end else if (r < (fill_phase ? 81 : 73)) begin
      it.op = OP_REMOVE;
      it.key_hash = pick_ring_key(75);
    end else begin
      it.op = OP_LOOKUP;
      it.key_hash = pick_ring_key(30);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  // Enter and leave at a falling edge; the item is predicted at the edge that takes it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring_expect_q.push_back(ring_apply(it));
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back and the block has settled
  task automatic wait_ring_idle();
    in_valid <= 1'b0;
    while (ring_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (ring_expect_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data), '0);
      end else begin
        want_res = ring_expect_q.pop_front();
        if (out_data.status !== want_res.status)
          report_mismatch("status", 32'(out_data.status), 32'(want_res.status));
        if (out_data.owner_out !== want_res.owner_out)
          report_mismatch("owner_out", 32'(out_data.owner_out), 32'(want_res.owner_out));
        if (out_data.entry_count !== want_res.entry_count)
          report_mismatch("entry_count", 32'(out_data.entry_count),
                          32'(want_res.entry_count));
      end
    end
  end

  task automatic test_ring_special_cases();
    send_idle_pct = 17;
    recv_stall_pct = 63;
    // empty table
    send_item(in_item_t'{OP_LOOKUP, 32'h0000_0000, 8'h00});
    send_item(in_item_t'{OP_REMOVE, 32'h0000_0007, 8'h00});
    send_item(in_item_t'{OP_UNDEF,  32'hFFFF_FFFF, 8'hFF});
    // extremes, duplicate, wrap
    send_item(in_item_t'{OP_INSERT, 32'h0000_0000, 8'h00});
    send_item(in_item_t'{OP_INSERT, 32'hFFFF_FFFF, 8'hFF});
    send_item(in_item_t'{OP_INSERT, 32'h0000_0000, 8'h55});
    send_item(in_item_t'{OP_LOOKUP, 32'h0000_0000, 8'hFF});
    send_item(in_item_t'{OP_LOOKUP, 32'h0000_0001, 8'h00});
    send_item(in_item_t'{OP_LOOKUP, 32'hFFFF_FFFF, 8'h00});
    send_item(in_item_t'{OP_INSERT, 32'h8000_0000, 8'hA5});
    send_item(in_item_t'{OP_LOOKUP, 32'h8000_0001, 8'h00});
    send_item(in_item_t'{OP_LOOKUP, 32'h7FFF_FFFF, 8'h00});
    send_item(in_item_t'{OP_REMOVE, 32'h1234_5678, 8'h00});
    // removing slot zero pulls the last slot down
    send_item(in_item_t'{OP_REMOVE, 32'h0000_0000, 8'hFF});
    send_item(in_item_t'{OP_LOOKUP, 32'h0000_0000, 8'h00});
    send_item(in_item_t'{OP_LOOKUP, 32'h8000_0001, 8'h00});
    send_item(in_item_t'{OP_REMOVE, 32'hFFFF_FFFF, 8'h00});
    send_item(in_item_t'{OP_LOOKUP, 32'h9000_0000, 8'hFF});
    send_item(in_item_t'{OP_UNDEF,  32'h8000_0000, 8'hFF});
    send_item(in_item_t'{OP_INSERT, 32'h0000_0001, 8'h3C});
    send_item(in_item_t'{OP_LOOKUP, 32'h0000_0001, 8'h00});
    send_item(in_item_t'{OP_REMOVE, 32'h8000_0000, 8'h00});
    send_item(in_item_t'{OP_REMOVE, 32'h0000_0001, 8'h00});
    send_item(in_item_t'{OP_LOOKUP, 32'hFFFF_FFFF, 8'h00});
    wait_ring_idle();
  endtask

  // Alternate fill-heavy and drain-heavy spans so the table swings between empty and full
  task automatic test_ring_random_ops(input int n_items, input int idle_pct,
                                      input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      send_item(random_ring_item(((rand_sent / FILL_SPAN) % 2) == 0));
      rand_sent++;
    end
    wait_ring_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    ring_used = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rand_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_ring_special_cases();
    test_ring_random_ops(384, 17, 63);
    test_ring_random_ops(383, 63, 17);
    test_ring_random_ops(383, 0, 0);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
